// File: hdl/wbmmr_pkg.sv
// Shared types and constants for the waveform bin min/max/rms block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package wbmmr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BIN     = 65536;
    localparam int LEN_BITS    = 17;
    localparam int SUM_BITS    = 47;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
    localparam int MEAN_BITS   = 2 * SAMPLE_BITS - 1;
    localparam int ROOT_BITS   = SAMPLE_BITS;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int RREM_BITS   = ROOT_BITS + 2;

    // one quotient bit per step, one root bit per step
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int ROOT_STEPS  = ROOT_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_in_bin;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] bin_min;
        logic signed [SAMPLE_BITS-1:0] bin_max;
        logic [ROOT_BITS-1:0]          bin_rms;
        logic [LEN_BITS-1:0]           bin_length;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic root_load;
        logic root_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/wbmmr_datapath.sv
// Datapath: bin accumulators, restoring divider, digit-by-digit square root
// and the result register. Depends on wbmmr_pkg; driven by wbmmr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module wbmmr_datapath
    import wbmmr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire in_t     s_data,
    input  wire cmd_t    cmd,
    output status_t      status,
    output logic         m_valid,
    input  wire logic    m_ready,
    output out_t         m_data
);

    // running bin state
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SUM_BITS-1:0]           sum_reg, sum_next;
    logic [LEN_BITS-1:0]           tally_reg, tally_next;

    // closed-bin snapshot
    logic signed [SAMPLE_BITS-1:0] res_min_reg;
    logic signed [SAMPLE_BITS-1:0] res_max_reg;
    logic [LEN_BITS-1:0]           den_reg;

    // divider
    logic [SUM_BITS-1:0]           quo_reg;
    logic [LEN_BITS-1:0]           rem_reg;
    logic [LEN_BITS:0]             rem_sh;
    logic                          div_ge;

    // square root
    logic [RAD_BITS-1:0]           rad_reg;
    logic [ROOT_BITS-1:0]          root_reg;
    logic [RREM_BITS-1:0]          rrem_reg;
    logic [RREM_BITS+1:0]          rrem_sh;
    logic [RREM_BITS+1:0]          trial;
    logic                          root_ge;

    logic                          m_valid_reg;
    out_t                          m_data_reg;

    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic [SQ_BITS-1:0]              sq;
    logic                            bin_open;

    always_comb begin
        prod     = s_data.sample * s_data.sample;
        sq       = prod[SQ_BITS-1:0];
        bin_open = (tally_reg != '0);

        min_next = (!bin_open || s_data.sample < min_reg) ? s_data.sample : min_reg;
        max_next = (!bin_open || s_data.sample > max_reg) ? s_data.sample : max_reg;
        sum_next = bin_open ? sum_reg + SUM_BITS'(sq) : SUM_BITS'(sq);
        tally_next = tally_reg + LEN_BITS'(1);

        status.close    = s_data.last_in_bin || (tally_next == LEN_BITS'(MAX_BIN));
        status.out_free = !m_valid_reg || m_ready;

        rem_sh = {rem_reg, quo_reg[SUM_BITS-1]};
        div_ge = (rem_sh >= {1'b0, den_reg});

        rrem_sh = {rrem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial   = (RREM_BITS+2)'({root_reg, 2'b01});
        root_ge = (rrem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            tally_reg <= '0;
        end else if (cmd.accept) begin
            if (status.close) begin
                min_reg   <= '0;
                max_reg   <= '0;
                sum_reg   <= '0;
                tally_reg <= '0;
            end else begin
                min_reg   <= min_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
                tally_reg <= tally_next;
            end
        end
    end

    // snapshot, divider and root registers carry payload only
    always_ff @(posedge aclk) begin
        if (cmd.accept && status.close) begin
            res_min_reg <= min_next;
            res_max_reg <= max_next;
            den_reg     <= tally_next;
            quo_reg     <= sum_next;
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? LEN_BITS'(rem_sh - {1'b0, den_reg}) : rem_sh[LEN_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], div_ge};
        end

        if (cmd.root_load) begin
            // mean never exceeds 2^30
            rad_reg  <= RAD_BITS'(quo_reg[MEAN_BITS-1:0]);
            root_reg <= '0;
            rrem_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rrem_reg <= root_ge ? RREM_BITS'(rrem_sh - trial) : rrem_sh[RREM_BITS-1:0];
            root_reg <= {root_reg[ROOT_BITS-2:0], root_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.bin_min    <= res_min_reg;
            m_data_reg.bin_max    <= res_max_reg;
            m_data_reg.bin_rms    <= root_reg;
            m_data_reg.bin_length <= den_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.close) |=> (tally_reg == '0))
        else $error("bin state not cleared after close");

    a_rms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.bin_rms <= ROOT_BITS'(1 << (SAMPLE_BITS-1))))
        else $error("rms out of range");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.bin_length != '0))
        else $error("empty bin reported");

endmodule

`default_nettype wire

// File: hdl/wbmmr_ctrl.sv
// Controller: sequences accumulate, divide, root and result hand-off.
// Depends on wbmmr_pkg; drives wbmmr_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module wbmmr_ctrl
    import wbmmr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(DIV_STEPS - 1);
    localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(ROOT_STEPS - 1);

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && status.close) begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_ROOT_LOAD;
                end
            end
            ST_ROOT_LOAD: begin
                cmd.root_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == ROOT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_close_to_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && status.close) |=> (state_reg == ST_DIVIDE))
        else $error("bin close did not start the divider");

    a_divide_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && cnt_reg == DIV_LAST) |=> (state_reg == ST_ROOT_LOAD))
        else $error("divider ran past its step count");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("result not handed off");

endmodule

`default_nettype wire

// File: hdl/waveform_bin_min_max_rms_core.sv
// Top level of the waveform bin min/max/rms block.
// Depends on wbmmr_pkg, wbmmr_ctrl and wbmmr_datapath.
//
// Usage:
//  - s_ channel: one Q1.15 sample per transfer with last_in_bin marking the
//    end of a display bin. A bin also closes on its MAX_BIN-th sample.
//  - m_ channel: one transfer per closed bin with min, max, truncated rms
//    and the sample count.
//  - Samples that do not close a bin are taken one per cycle when idle.
//  - A closing sample starts the divide (one quotient bit per step) and
//    the square root (one root bit per step after a load step); s_ready
//    stays low through these and while the result waits to be loaded,
//    and the result reaches m_ as s_ready rises again.
//  - The result sits in an output register: while it waits for m_ready the
//    next bin is accumulated. A second finished bin waits inside until the
//    register frees, with s_ready low.
//  - aresetn (synchronous, active low) empties the open bin and the result
//    register.
`timescale 1ns / 1ps
`default_nettype none

module waveform_bin_min_max_rms_core
    import wbmmr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    cmd_t    cmd;
    status_t status;

    wbmmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wbmmr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: tb/waveform_bin_min_max_rms_core_test.sv
// Self-checking testbench for waveform_bin_min_max_rms_core: directed bins and random
// bin streams, each closed bin checked against its table entry or a bin-summary predictor.
// Depends on wbmmr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module waveform_bin_min_max_rms_core_test;
    import wbmmr_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int RANDOM_SAMPLES = 1880;
    localparam int QUIET_TAIL     = 300;
    localparam int SETTLE_CYCLES  = 200;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = 16'sh7fff;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic                          typed;
        out_t                          want;
    } drill_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // open-bin state of the predictor
    logic signed [SAMPLE_BITS-1:0] open_min   = '0;
    logic signed [SAMPLE_BITS-1:0] open_max   = '0;
    logic [SUM_BITS-1:0]           open_sumsq = '0;
    logic [LEN_BITS-1:0]           open_count = '0;

    out_t pending_bins [$];
    int   samples_sent   = 0;
    int   bins_checked   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   idle_pct       = 0;
    int   stall_pct      = 0;
    int   stall_left     = 0;

    drill_row_t drill_rows [23];

    always #HALF_PERIOD aclk = ~aclk;

    waveform_bin_min_max_rms_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic logic [ROOT_BITS:0] floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_BITS; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[ROOT_BITS:0];
    endfunction

    // Folds one sample into the open bin; on close returns the bin summary and empties the bin.
    task automatic fold_sample(input in_t item, output bit closed, output out_t bin);
        longint          sv;
        longint unsigned sq;
        longint unsigned mean;
        logic [ROOT_BITS:0] root;
        sv = item.sample;
        sq = sv * sv;
        if (open_count == 0) begin
            open_min   = item.sample;
            open_max   = item.sample;
            open_sumsq = SUM_BITS'(sq);
        end else begin
            if (item.sample < open_min)
                open_min = item.sample;
            if (item.sample > open_max)
                open_max = item.sample;
            open_sumsq = open_sumsq + SUM_BITS'(sq);
        end
        open_count = open_count + 1'b1;
        closed = item.last_in_bin || (open_count >= MAX_BIN);
        bin = '0;
        if (closed) begin
            mean = open_sumsq / open_count;
            root = floor_root(mean);
            bin.bin_min    = open_min;
            bin.bin_max    = open_max;
            bin.bin_rms    = root[ROOT_BITS-1:0];
            bin.bin_length = open_count;
            open_min   = '0;
            open_max   = '0;
            open_sumsq = '0;
            open_count = '0;
        end
    endtask

    // Called at a rising edge; returns at the edge where the sample is transferred.
    task automatic send_sample(input in_t item, input bit typed, input out_t want);
        bit   closed;
        out_t bin;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        fold_sample(item, closed, bin);
        if (closed)
            pending_bins.push_back(typed ? want : bin);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int t;
        t = $urandom_range(0, 16) - 8;
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return t[SAMPLE_BITS-1:0];
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_bin_span();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(1, 4);
        else if (r < 17)
            return $urandom_range(5, 16);
        else if (r < 19)
            return $urandom_range(17, 64);
        return $urandom_range(100, 300);
    endfunction

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_pct == 0) begin
            m_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : bin_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bins.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected bin transfer min=%0d max=%0d rms=%0d len=%0d",
                             $realtime, m_data.bin_min, m_data.bin_max, m_data.bin_rms,
                             m_data.bin_length);
            end else begin
                want = pending_bins.pop_front();
                bins_checked++;
                if (m_data.bin_min !== want.bin_min || m_data.bin_max !== want.bin_max ||
                    m_data.bin_rms !== want.bin_rms ||
                    m_data.bin_length !== want.bin_length) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: bin %0d exp min=%0d max=%0d rms=%0d len=%0d",
                                 $realtime, bins_checked, want.bin_min, want.bin_max,
                                 want.bin_rms, want.bin_length);
                        $display("    got min=%0d max=%0d rms=%0d len=%0d",
                                 m_data.bin_min, m_data.bin_max, m_data.bin_rms,
                                 m_data.bin_length);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d bins outstanding", cycle_count,
                 pending_bins.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        in_t item;
        int  random_sent;
        int  bin_index;
        int  span;
        random_sent = 0;
        bin_index   = 0;

        drill_rows = '{
            '{sample: 16'sd0,    last: 1'b1, typed: 1'b1, want: '{16'sd0, 16'sd0, 16'd0, 17'd1}},
            '{sample: MOST_POS,  last: 1'b1, typed: 1'b1,
              want: '{MOST_POS, MOST_POS, 16'd32767, 17'd1}},
            '{sample: MOST_NEG,  last: 1'b1, typed: 1'b1,
              want: '{MOST_NEG, MOST_NEG, 16'h8000, 17'd1}},
            '{sample: -16'sd1,   last: 1'b1, typed: 1'b1, want: '{-16'sd1, -16'sd1, 16'd1, 17'd1}},
            '{sample: 16'sd1,    last: 1'b1, typed: 1'b1, want: '{16'sd1, 16'sd1, 16'd1, 17'd1}},
            '{sample: MOST_NEG,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: MOST_POS,  last: 1'b1, typed: 1'b0, want: '0},
            '{sample: 16'sd100,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: -16'sd200, last: 1'b0, typed: 1'b0, want: '0},
            '{sample: 16'sd300,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: -16'sd400, last: 1'b1, typed: 1'b0, want: '0},
            '{sample: 16'sd5,    last: 1'b0, typed: 1'b0, want: '0},
            '{sample: 16'sd5,    last: 1'b0, typed: 1'b0, want: '0},
            '{sample: 16'sd5,    last: 1'b1, typed: 1'b1, want: '{16'sd5, 16'sd5, 16'd5, 17'd3}},
            '{sample: MOST_NEG,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: MOST_NEG,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: MOST_NEG,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: MOST_NEG,  last: 1'b1, typed: 1'b1,
              want: '{MOST_NEG, MOST_NEG, 16'h8000, 17'd4}},
            '{sample: 16'sh5555, last: 1'b0, typed: 1'b0, want: '0},
            '{sample: 16'shaaaa, last: 1'b0, typed: 1'b0, want: '0},
            '{sample: 16'sd0,    last: 1'b1, typed: 1'b0, want: '0},
            '{sample: MOST_POS,  last: 1'b0, typed: 1'b0, want: '0},
            '{sample: MOST_POS,  last: 1'b1, typed: 1'b1,
              want: '{MOST_POS, MOST_POS, 16'd32767, 17'd2}}
        };

        idle_pct  = 30;
        stall_pct = 30;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (drill_rows[i]) begin
            item.sample      = drill_rows[i].sample;
            item.last_in_bin = drill_rows[i].last;
            send_sample(item, drill_rows[i].typed, drill_rows[i].want);
        end

        while (random_sent < RANDOM_SAMPLES) begin
            if (random_sent >= RANDOM_SAMPLES - QUIET_TAIL) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else if (bin_index % 8 == 0) begin
                idle_pct  = 25 * $urandom_range(0, 2);
                stall_pct = 25 * $urandom_range(0, 2);
            end
            span = pick_bin_span();
            for (int k = 0; k < span; k++) begin
                item.sample      = pick_sample();
                item.last_in_bin = (k == span - 1);
                send_sample(item, 1'b0, '0);
                random_sent++;
            end
            bin_index++;
        end
        s_valid <= 1'b0;

        while (pending_bins.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d samples (directed bins, %0d random bins)",
                 samples_sent, bin_index);
        $display("Checked %0d closed bins, %0d mismatches", bins_checked, mismatch_count);
        if (mismatch_count == 0 && pending_bins.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/wbmmr_pkg.sv
hdl/wbmmr_datapath.sv
hdl/wbmmr_ctrl.sv
hdl/waveform_bin_min_max_rms_core.sv
tb/waveform_bin_min_max_rms_core_test.sv
